// File: design/mclbb_pkg.sv
// ----------------------------------------------------------------------------
// mclbb_pkg
// Shared types and constants of the multi-channel linear byte buffer.
// ----------------------------------------------------------------------------
package mclbb_pkg;

	localparam int MaxBuffers  = 8;
	localparam int BufferBytes = 1024;
	localparam int MaxTransfer = 64;
	localparam int BufW        = 3;
	localparam int PosW        = 10;
	localparam int LvlW        = 11;
	localparam int AddrW       = BufW + PosW;

	localparam logic [3:0] OP_ADD   = 4'd0;
	localparam logic [3:0] OP_CLEAR = 4'd1;
	localparam logic [3:0] OP_COPY  = 4'd2;
	localparam logic [3:0] OP_MOVE  = 4'd3;
	localparam logic [3:0] OP_MOVAT = 4'd4;
	localparam logic [3:0] OP_XFER  = 4'd5;
	localparam logic [3:0] OP_SETF  = 4'd6;
	localparam logic [3:0] OP_RAISE = 4'd7;
	localparam logic [3:0] OP_QUERY = 4'd8;

	localparam logic [1:0] REG_BLOCK = 2'd0;
	localparam logic [1:0] REG_CAP   = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	typedef struct packed {
		logic [3:0]  operation;
		logic [7:0]  buffer_index;
		logic [2:0]  dest_index;
		logic [7:0]  data_byte;
		logic [9:0]  start_offset;
		logic [6:0]  transfer_size;
		logic        discard;
		logic [10:0] fill_value;
	} cmd_t;

	typedef struct packed {
		logic [7:0]  byte_out;
		logic        last;
		logic [10:0] granted;
		logic [11:0] overshoot;
		logic [10:0] fill_level;
		logic [10:0] free_space;
	} res_t;

endpackage

// File: design/mclbb_cmd_fifo.sv
// ----------------------------------------------------------------------------
// mclbb_cmd_fifo
// Short command queue between the input side and the execution engine.
// ----------------------------------------------------------------------------
module mclbb_cmd_fifo (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mclbb_pkg::cmd_t in_cmd,
	output logic            out_valid,
	input  logic            out_ready,
	output mclbb_pkg::cmd_t out_cmd
);
	import mclbb_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready  = (cnt_q != 2'd2);
	assign out_valid = (cnt_q != 2'd0);
	assign out_cmd   = mem_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// File: design/mclbb_engine.sv
// ----------------------------------------------------------------------------
// mclbb_engine
// Executes buffer commands over the byte memory, one byte access per cycle.
// ----------------------------------------------------------------------------
module mclbb_engine (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_ready,
	input  mclbb_pkg::cmd_t  cmd,
	input  logic [6:0]       block_size,
	input  logic [10:0]      capacity,
	input  logic [3:0]       buffer_count,
	output logic             res_valid,
	input  logic             res_ready,
	output mclbb_pkg::res_t  res
);
	import mclbb_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DEC  = 4'd1;
	localparam logic [3:0] S_RD   = 4'd2;
	localparam logic [3:0] S_RDW  = 4'd3;
	localparam logic [3:0] S_EMIT = 4'd4;
	localparam logic [3:0] S_SH   = 4'd5;
	localparam logic [3:0] S_SHW  = 4'd6;
	localparam logic [3:0] S_APP  = 4'd7;
	localparam logic [3:0] S_STAT = 4'd8;
	localparam logic [3:0] S_OUT  = 4'd9;
	localparam logic [3:0] S_DIV  = 4'd10;
	localparam logic [3:0] S_APW  = 4'd11;

	logic [7:0]      mem [MaxBuffers*BufferBytes];
	logic [7:0]      rdata_q;
	logic            we;
	logic [AddrW-1:0] waddr, raddr;
	logic [7:0]      wdata;

	logic [LvlW-1:0] fill_q [MaxBuffers];
	logic [7:0]      tmp_q [MaxTransfer];
	logic [7:0]      tmp_rd_q;

	logic [3:0]      st_q;
	cmd_t            c_q;
	logic [6:0]      bs_q;
	logic [10:0]     cap_q;
	logic [3:0]      cnt_q;
	logic [6:0]      rv_q;
	logic [6:0]      i_q;
	logic [PosW:0]   pos_q;
	logic [PosW:0]   start_q;
	logic            emit_q;
	logic [11:0]     over_q;
	logic            zero_q;
	logic            all_q;
	res_t            res_q;
	logic            rv_q_valid;
	logic [6:0]      rem_q;
	logic [2:0]      dv_q;

	logic [BufW-1:0] b, d;
	logic [LvlW-1:0] fb, fd, fb_n;
	logic [6:0]      size_c, rounded;
	logic [7:0]      rem_sh;
	logic [LvlW:0]   sum_c;
	logic [LvlW-1:0] room_b, room_d;
	logic [6:0]      rv_c;
	logic [LvlW:0]   mag_c;

	assign cmd_ready = (st_q == S_IDLE);
	assign res_valid = rv_q_valid;
	assign res       = res_q;

	assign b  = c_q.buffer_index[BufW-1:0];
	assign d  = c_q.dest_index;
	assign fb = fill_q[b];
	assign fd = fill_q[d];
	assign size_c = (c_q.transfer_size > 7'(MaxTransfer)) ? 7'(MaxTransfer) : c_q.transfer_size;
	assign sum_c  = {1'b0, fb} + {1'b0, c_q.fill_value};
	assign room_b = (fb >= cap_q) ? '0 : cap_q - fb;
	assign room_d = (fd >= cap_q) ? '0 : cap_q - fd;
	assign mag_c  = sum_c - {1'b0, cap_q};

	// block rounding: restoring divide, one quotient bit per cycle
	assign rem_sh  = {rem_q, size_c[dv_q]};
	assign rounded = size_c - rem_q;

	always_comb begin
		rv_c = '0;
		unique case (c_q.operation)
			OP_MOVE: rv_c = ({4'd0, rounded} < fb) ? rounded : fb[6:0];
			OP_XFER: begin
				rv_c = ({4'd0, rounded} < fb) ? rounded : fb[6:0];
				if ({4'd0, rv_c} > room_d) rv_c = room_d[6:0];
			end
			default: rv_c = rounded;
		endcase
	end

	assign fb_n = fill_q[b];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = rdata_q;
		raddr = '0;
		unique case (st_q)
			S_DEC: begin
				we    = (c_q.operation == OP_ADD) && (room_b != '0);
				waddr = {b, fb[PosW-1:0]};
				wdata = c_q.data_byte;
			end
			S_RD: raddr = {b, pos_q[PosW-1:0]};
			S_SH: raddr = {b, PosW'(pos_q + {4'd0, rv_q})};
			S_SHW: begin
				we    = 1'b1;
				waddr = {b, pos_q[PosW-1:0]};
			end
			S_APW: begin
				we    = 1'b1;
				waddr = {d, PosW'(fd + {4'd0, i_q})};
				wdata = tmp_rd_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (st_q == S_RDW) tmp_q[i_q[5:0]] <= rdata_q;
		tmp_rd_q <= tmp_q[i_q[5:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			bs_q       <= 7'd1;
			cap_q      <= 11'd1024;
			cnt_q      <= 4'd8;
			rv_q_valid <= 1'b0;
			for (int k = 0; k < MaxBuffers; k++) fill_q[k] <= '0;
		end else begin
			if (res_valid && res_ready) rv_q_valid <= 1'b0;
			unique case (st_q)
				S_IDLE: begin
					if (cmd_valid) begin
						c_q   <= cmd;
						bs_q  <= (block_size == '0) ? 7'd1 : block_size;
						cap_q <= (capacity == '0) ? 11'd1 :
							(capacity > 11'(BufferBytes)) ? 11'(BufferBytes) : capacity;
						cnt_q <= (buffer_count > 4'(MaxBuffers)) ? 4'(MaxBuffers) : buffer_count;
						rem_q <= '0;
						dv_q  <= 3'd6;
						st_q  <= S_DIV;
					end
				end
				S_DIV: begin
					if (rem_sh >= {1'b0, bs_q}) rem_q <= 7'(rem_sh - {1'b0, bs_q});
					else rem_q <= rem_sh[6:0];
					if (dv_q == 3'd0) st_q <= S_DEC;
					else dv_q <= dv_q - 3'd1;
				end
				S_DEC: begin
					rv_q   <= '0;
					over_q <= '0;
					emit_q <= 1'b0;
					zero_q <= 1'b0;
					all_q  <= 1'b0;
					i_q    <= '0;
					st_q   <= S_STAT;
					if (c_q.operation == OP_CLEAR && c_q.buffer_index == 8'd255) begin
						for (int k = 0; k < MaxBuffers; k++)
							if (4'(k) < cnt_q) fill_q[k] <= '0;
						all_q <= 1'b1;
					end else if (c_q.operation > OP_QUERY ||
						{4'd0, c_q.buffer_index} >= {8'd0, cnt_q}) begin
						zero_q <= 1'b1;
					end else begin
						unique case (c_q.operation)
							OP_ADD: if (room_b != '0) begin
								fill_q[b] <= fb + 1'b1;
								rv_q <= 7'd1;
							end
							OP_CLEAR: fill_q[b] <= '0;
							OP_COPY, OP_MOVAT: begin
								if (size_c >= bs_q && {1'b0, c_q.start_offset} +
									{4'd0, size_c} <= fb && rounded != '0) begin
									rv_q    <= rounded;
									pos_q   <= {1'b0, c_q.start_offset};
									start_q <= {1'b0, c_q.start_offset};
									emit_q  <= (c_q.operation == OP_COPY) || !c_q.discard;
									st_q    <= S_RD;
								end
							end
							OP_MOVE: if (size_c >= bs_q && rv_c != '0) begin
								rv_q <= rv_c; pos_q <= '0; start_q <= '0;
								emit_q <= !c_q.discard; st_q <= S_RD;
							end
							OP_XFER: if ({1'b0, d} < cnt_q && bs_q < size_c && rv_c != '0) begin
								rv_q <= rv_c; pos_q <= '0; start_q <= '0;
								st_q <= S_RD;
							end
							OP_SETF, OP_RAISE: begin
								if (sum_c <= {1'b0, cap_q}) begin
									fill_q[b] <= (c_q.operation == OP_RAISE) ?
										sum_c[LvlW-1:0] : c_q.fill_value;
								end else begin
									fill_q[b] <= cap_q;
									over_q <= (mag_c > 12'd2048) ? 12'h800 : 12'h000 - mag_c;
								end
							end
							default: ;
						endcase
					end
				end
				S_RD: st_q <= S_RDW;
				S_RDW: begin
					pos_q <= pos_q + 1'b1;
					if (i_q + 1'b1 == rv_q) begin
						pos_q <= start_q;
						st_q  <= (c_q.operation == OP_COPY) ? S_EMIT : S_SH;
						i_q   <= (c_q.operation == OP_COPY) ? '0 : i_q;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_RD;
					end
				end
				S_SH: begin
					if (pos_q + {4'd0, rv_q} < {1'b0, fb}) st_q <= S_SHW;
					else begin
						fill_q[b] <= fb - {4'd0, rv_q};
						i_q <= '0;
						st_q <= (c_q.operation == OP_XFER) ? S_APP : S_EMIT;
					end
				end
				S_SHW: begin
					pos_q <= pos_q + 1'b1;
					st_q  <= S_SH;
				end
				S_APP: st_q <= S_APW;
				S_APW: begin
					if (i_q + 1'b1 == rv_q) begin
						fill_q[d] <= fd + {4'd0, rv_q};
						st_q <= S_STAT;
					end else begin
						i_q  <= i_q + 1'b1;
						st_q <= S_APP;
					end
				end
				S_EMIT: begin
					if (!emit_q) st_q <= S_STAT;
					else if (!rv_q_valid || res_ready) begin
						rv_q_valid <= 1'b1;
						res_q.byte_out   <= tmp_q[i_q[5:0]];
						res_q.last       <= (i_q + 1'b1 == rv_q);
						res_q.granted    <= {4'd0, rv_q};
						res_q.overshoot  <= '0;
						res_q.fill_level <= fb;
						res_q.free_space <= room_b;
						if (i_q + 1'b1 == rv_q) st_q <= S_IDLE;
						else i_q <= i_q + 1'b1;
					end
				end
				S_STAT: st_q <= S_OUT;
				S_OUT: begin
					if (!rv_q_valid || res_ready) begin
						rv_q_valid <= 1'b1;
						res_q.byte_out   <= '0;
						res_q.last       <= 1'b1;
						res_q.granted    <= zero_q ? '0 : {4'd0, rv_q};
						res_q.overshoot  <= zero_q ? '0 : over_q;
						res_q.fill_level <= (zero_q || all_q) ? '0 : fb_n;
						res_q.free_space <= zero_q ? '0 : all_q ? cap_q : room_b;
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

// File: design/multi_channel_linear_byte_buffer_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_linear_byte_buffer_unit
// Up to eight linear byte buffers with append, read, remove, transfer, clear, fill-level and query commands.
// ----------------------------------------------------------------------------
// Commands enter a two-entry queue and run one at a time in the engine, which
// can make one write and one registered read of the byte memory per cycle. Every
// command first rounds its length down to whole blocks with a restoring divide;
// status-only commands then go straight to the result, a read first copies its
// bytes to a staging array and then emits them, a removal shifts the bytes behind
// the gap down, and a transfer then appends the removed bytes to its destination.
module multi_channel_linear_byte_buffer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [55:0] s_axis_tdata,  // operation, buffer_index, dest_index, data_byte,
	                                   // start_offset, transfer_size, discard, fill_value
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,  // byte_out, granted, overshoot, fill_level, free_space
	output logic        m_axis_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);
	import mclbb_pkg::*;

	cmd_t        in_cmd, q_cmd;
	res_t        r;
	logic        q_valid, q_ready;
	logic [6:0]  block_q;
	logic [10:0] cap_q;
	logic [3:0]  count_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			block_q <= 7'd1;
			cap_q   <= 11'd1024;
			count_q <= 4'd8;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BLOCK: block_q <= cfg_data[6:0];
				REG_CAP:   cap_q   <= cfg_data;
				REG_COUNT: count_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign in_cmd.operation     = s_axis_tdata[3:0];
	assign in_cmd.buffer_index  = s_axis_tdata[11:4];
	assign in_cmd.dest_index    = s_axis_tdata[14:12];
	assign in_cmd.data_byte     = s_axis_tdata[22:15];
	assign in_cmd.start_offset  = s_axis_tdata[32:23];
	assign in_cmd.transfer_size = s_axis_tdata[39:33];
	assign in_cmd.discard       = s_axis_tdata[40];
	assign in_cmd.fill_value    = s_axis_tdata[51:41];

	mclbb_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_cmd(in_cmd),
		.out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
	);

	mclbb_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_cmd),
		.block_size(block_q), .capacity(cap_q), .buffer_count(count_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(r)
	);

	assign m_axis_tlast = r.last;
	assign m_axis_tdata = {3'b0, r.free_space, r.fill_level, r.overshoot, r.granted, r.byte_out};
endmodule
